FILE: rtl/core/iat_pkg.sv
package iat_pkg;

  localparam int DEPTH_DEF      = 256;
  localparam int DATA_WIDTH_DEF = 32;

  // request kinds
  localparam logic [2:0] KIND_APPEND = 3'd0;
  localparam logic [2:0] KIND_INSERT = 3'd1;
  localparam logic [2:0] KIND_UPDATE = 3'd2;
  localparam logic [2:0] KIND_REMOVE = 3'd3;
  localparam logic [2:0] KIND_READ   = 3'd4;

  // result status
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]         status;
    logic [8:0]         capacity_now;
    logic [8:0]         size_now;
    logic signed [31:0] read_value;
  } res_t;

endpackage

FILE: rtl/core/indexed_array_table.sv
// Ordered array of signed words held in one on-chip memory of DEPTH entries.
// Input channel in_*: one request per item (append, insert before index,
// update at index, remove at index, read at index). Result channel out_*:
// exactly one result item per request, in request order, giving the read
// word, the new size, the reported capacity and a status.
// Append, update, rejected and unknown requests go straight to the result
// stage; a read first waits for the registered memory output. Insert and
// remove shift the entries between the index and the top, and insert then
// writes the new word (remove shifts nothing when the top entry goes): the
// shift moves one entry per cycle through the memory's single read and
// single write port. One request is worked on at a time; in_tready is high
// only between requests and comes back in the cycle after a result moves to
// the output register. The next request is taken while an earlier result
// still waits; if out_tready stays low, the following result holds inside
// the block until the register frees up. Reset empties the array and clears
// the reported capacity; the memory itself is not cleared, since no entry at
// or above the size is ever read.
module indexed_array_table #(
  parameter int DEPTH      = iat_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = iat_pkg::DATA_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // kind[2:0], index[10:3], value[42:11], zero fill
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata   // read_value[31:0], size_now[40:32],
                                  // capacity_now[49:41], status[51:50], zero fill
);

  localparam int AW = $clog2(DEPTH);

  logic                  mem_rd_en;
  logic [AW-1:0]         mem_rd_addr;
  logic [DATA_WIDTH-1:0] mem_rd_data;
  logic                  mem_wr_en;
  logic [AW-1:0]         mem_wr_addr;
  logic [DATA_WIDTH-1:0] mem_wr_data;
  logic                  res_valid;
  logic                  res_taken;
  iat_pkg::res_t         res;
  iat_pkg::res_t         out_r;
  logic                  out_valid_r, out_valid_nxt;

  iat_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  iat_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_kind     (in_tdata[2:0]),
    .in_index    (in_tdata[10:3]),
    .in_value    (in_tdata[42:11]),
    .in_ready    (in_tready),
    .res_valid   (res_valid),
    .res         (res),
    .res_taken   (res_taken),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data)
  );

  // output register loads when empty or emptied in the same cycle
  assign res_taken     = res_valid && (!out_valid_r || out_tready);
  assign out_valid_nxt = res_taken || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_taken) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_r};

  a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[40:32] <= 9'(DEPTH))
    else $error("size beyond store depth");

  a_cap_covers_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[49:41] >= out_tdata[40:32])
    else $error("reported capacity below size");

  a_full_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[51:50] == iat_pkg::ST_FULL |-> out_tdata[40:32] == 9'(DEPTH))
    else $error("full status with room left");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken while busy");

endmodule

FILE: rtl/core/iat_ram.sv
module iat_ram #(
  parameter int WIDTH = iat_pkg::DATA_WIDTH_DEF,
  parameter int DEPTH = iat_pkg::DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/core/iat_ctrl.sv
module iat_ctrl #(
  parameter int DEPTH      = iat_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = iat_pkg::DATA_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic [2:0]               in_kind,
  input  logic [7:0]               in_index,
  input  logic signed [31:0]       in_value,
  output logic                     in_ready,
  output logic                     res_valid,
  output iat_pkg::res_t            res,
  input  logic                     res_taken,
  output logic                     mem_rd_en,
  output logic [$clog2(DEPTH)-1:0] mem_rd_addr,
  input  logic [DATA_WIDTH-1:0]    mem_rd_data,
  output logic                     mem_wr_en,
  output logic [$clog2(DEPTH)-1:0] mem_wr_addr,
  output logic [DATA_WIDTH-1:0]    mem_wr_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > 8) ? CW : 8;
  localparam logic [CW:0] DEPTH_X = (CW + 1)'(DEPTH);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SHIFT  = 3'd1;
  localparam logic [2:0] S_DRAIN  = 3'd2;
  localparam logic [2:0] S_PUT    = 3'd3;
  localparam logic [2:0] S_RDWAIT = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0]            state_r, state_nxt;
  logic [2:0]            kind_r, kind_nxt;
  logic [AW-1:0]         idx_r, idx_nxt;
  logic [DATA_WIDTH-1:0] word_r, word_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [CW-1:0]         cap_r, cap_nxt;
  logic [AW-1:0]         ptr_r, ptr_nxt;
  logic [AW-1:0]         end_r, end_nxt;
  logic [AW-1:0]         last_r, last_nxt;
  logic                  pend_r, pend_nxt;
  logic [1:0]            stat_r, stat_nxt;
  logic [DATA_WIDTH-1:0] rdv_r, rdv_nxt;

  logic signed [63:0]    value_ext;
  logic signed [63:0]    rdv_ext;
  logic [DATA_WIDTH-1:0] word_in;
  logic [XW-1:0]         idx_x;
  logic [XW-1:0]         cnt_x;
  logic                  range_bad;
  logic                  full;
  logic [CW:0]           cap_grown;
  logic [CW-1:0]         cap_next;
  logic                  shift_up;
  logic [AW-1:0]         shift_tgt;

  assign value_ext = 64'(in_value);
  assign word_in   = value_ext[DATA_WIDTH-1:0];
  assign idx_x     = XW'(in_index);
  assign cnt_x     = XW'(count_r);
  assign range_bad = idx_x >= cnt_x;
  assign full      = count_r == CW'(DEPTH);

  // capacity starts at 4 and doubles once the size catches up, capped at depth
  always_comb begin
    cap_grown = (cap_r == '0) ? (CW + 1)'(4) : {cap_r, 1'b0};
    if (cap_grown > DEPTH_X) begin
      cap_grown = DEPTH_X;
    end
    cap_next = (cap_r <= count_r) ? cap_grown[CW-1:0] : cap_r;
  end

  // insert moves entries up, remove moves them down; the pending write never
  // hits the address being read in the same cycle
  assign shift_up  = kind_r == iat_pkg::KIND_INSERT;
  assign shift_tgt = shift_up ? last_r + AW'(1) : last_r - AW'(1);

  always_comb begin
    state_nxt   = state_r;
    kind_nxt    = kind_r;
    idx_nxt     = idx_r;
    word_nxt    = word_r;
    count_nxt   = count_r;
    cap_nxt     = cap_r;
    ptr_nxt     = ptr_r;
    end_nxt     = end_r;
    last_nxt    = last_r;
    pend_nxt    = pend_r;
    stat_nxt    = stat_r;
    rdv_nxt     = rdv_r;
    mem_rd_en   = 1'b0;
    mem_rd_addr = ptr_r;
    mem_wr_en   = 1'b0;
    mem_wr_addr = shift_tgt;
    mem_wr_data = mem_rd_data;
    res_valid   = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt  = in_kind;
          idx_nxt   = AW'(in_index);
          word_nxt  = word_in;
          stat_nxt  = iat_pkg::ST_OK;
          rdv_nxt   = '0;
          pend_nxt  = 1'b0;
          state_nxt = S_DONE;
          unique case (in_kind)
            iat_pkg::KIND_APPEND: begin
              if (full) begin
                stat_nxt = iat_pkg::ST_FULL;
              end else begin
                cap_nxt     = cap_next;
                mem_wr_en   = 1'b1;
                mem_wr_addr = AW'(count_r);
                mem_wr_data = word_in;
                count_nxt   = count_r + CW'(1);
              end
            end
            iat_pkg::KIND_INSERT: begin
              if (range_bad) begin
                stat_nxt = iat_pkg::ST_RANGE;
              end else if (full) begin
                stat_nxt = iat_pkg::ST_FULL;
              end else begin
                cap_nxt   = cap_next;
                count_nxt = count_r + CW'(1);
                ptr_nxt   = AW'(count_r - CW'(1));
                end_nxt   = AW'(in_index);
                state_nxt = S_SHIFT;
              end
            end
            iat_pkg::KIND_UPDATE: begin
              if (range_bad) begin
                stat_nxt = iat_pkg::ST_RANGE;
              end else begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = AW'(in_index);
                mem_wr_data = word_in;
              end
            end
            iat_pkg::KIND_REMOVE: begin
              if (range_bad) begin
                stat_nxt = iat_pkg::ST_RANGE;
              end else begin
                count_nxt = count_r - CW'(1);
                // removing the top entry needs no shift
                if (idx_x != cnt_x - XW'(1)) begin
                  ptr_nxt   = AW'(in_index) + AW'(1);
                  end_nxt   = AW'(count_r - CW'(1));
                  state_nxt = S_SHIFT;
                end
              end
            end
            iat_pkg::KIND_READ: begin
              if (range_bad) begin
                stat_nxt = iat_pkg::ST_RANGE;
              end else begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = AW'(in_index);
                state_nxt   = S_RDWAIT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SHIFT: begin
        mem_rd_en = 1'b1;
        mem_wr_en = pend_r;
        last_nxt  = ptr_r;
        pend_nxt  = 1'b1;
        if (ptr_r == end_r) begin
          state_nxt = S_DRAIN;
        end else begin
          ptr_nxt = shift_up ? ptr_r - AW'(1) : ptr_r + AW'(1);
        end
      end
      S_DRAIN: begin
        mem_wr_en = 1'b1;
        pend_nxt  = 1'b0;
        state_nxt = shift_up ? S_PUT : S_DONE;
      end
      S_PUT: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = idx_r;
        mem_wr_data = word_r;
        state_nxt   = S_DONE;
      end
      S_RDWAIT: begin
        rdv_nxt   = mem_rd_data;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_taken) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_ready = state_r == S_IDLE;

  assign rdv_ext          = 64'(signed'(rdv_r));
  assign res.read_value   = rdv_ext[31:0];
  assign res.size_now     = 9'(count_r);
  assign res.capacity_now = 9'(cap_r);
  assign res.status       = stat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      cap_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      cap_r   <= cap_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    idx_r  <= idx_nxt;
    word_r <= word_nxt;
    ptr_r  <= ptr_nxt;
    end_r  <= end_nxt;
    last_r <= last_nxt;
    stat_r <= stat_nxt;
    rdv_r  <= rdv_nxt;
  end

endmodule

FILE: bench/tb_indexed_array_table.sv
module tb_indexed_array_table;

  localparam int DEPTH        = iat_pkg::DEPTH_DEF;
  localparam int RANDOM_ITEMS = 830;
  localparam int HOLD_AT      = 40;   // result count at which the long hold-off starts
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 4000;
  localparam int PLAN_LEN     = 23;

  // kinds the block has no use for
  localparam logic [2:0] KIND_RSVD_A = 3'd5;
  localparam logic [2:0] KIND_RSVD_B = 3'd6;
  localparam logic [2:0] KIND_RSVD_C = 3'd7;

  typedef enum int {FILL, AT_FULL, DRAIN, MIXED} phase_t;

  typedef struct packed {
    logic [2:0]    kind;
    logic [7:0]    index;
    logic [31:0]   value;
    logic          typed;
    iat_pkg::res_t want;
  } step_t;

  // want fields: status, capacity_now, size_now, read_value
  localparam step_t PLAN [PLAN_LEN] = '{
    '{iat_pkg::KIND_READ,   8'd0,   32'h0000_0000, 1'b1,
      '{iat_pkg::ST_RANGE, 9'd0, 9'd0, 32'h0}},
    '{iat_pkg::KIND_INSERT, 8'd0,   32'h1111_1111, 1'b1,
      '{iat_pkg::ST_RANGE, 9'd0, 9'd0, 32'h0}},
    '{iat_pkg::KIND_UPDATE, 8'd0,   32'h2222_2222, 1'b1,
      '{iat_pkg::ST_RANGE, 9'd0, 9'd0, 32'h0}},
    '{iat_pkg::KIND_REMOVE, 8'd0,   32'h0000_0000, 1'b1,
      '{iat_pkg::ST_RANGE, 9'd0, 9'd0, 32'h0}},
    '{KIND_RSVD_A,          8'd0,   32'h0000_0000, 1'b1,
      '{iat_pkg::ST_OK,    9'd0, 9'd0, 32'h0}},
    '{iat_pkg::KIND_APPEND, 8'd0,   32'h8000_0000, 1'b1,
      '{iat_pkg::ST_OK,    9'd4, 9'd1, 32'h0}},
    '{iat_pkg::KIND_APPEND, 8'd255, 32'h7FFF_FFFF, 1'b1,
      '{iat_pkg::ST_OK,    9'd4, 9'd2, 32'h0}},
    '{iat_pkg::KIND_READ,   8'd0,   32'h0000_0000, 1'b1,
      '{iat_pkg::ST_OK,    9'd4, 9'd2, 32'h8000_0000}},
    '{iat_pkg::KIND_READ,   8'd1,   32'hFFFF_FFFF, 1'b1,
      '{iat_pkg::ST_OK,    9'd4, 9'd2, 32'h7FFF_FFFF}},
    '{iat_pkg::KIND_READ,   8'd2,   32'h0000_0000, 1'b1,
      '{iat_pkg::ST_RANGE, 9'd4, 9'd2, 32'h0}},
    '{iat_pkg::KIND_READ,   8'd255, 32'h0000_0000, 1'b1,
      '{iat_pkg::ST_RANGE, 9'd4, 9'd2, 32'h0}},
    '{iat_pkg::KIND_INSERT, 8'd0,   32'hFFFF_FFFF, 1'b0, '0},
    '{iat_pkg::KIND_INSERT, 8'd2,   32'h0000_0000, 1'b0, '0},
    '{iat_pkg::KIND_APPEND, 8'd0,   32'h1234_5678, 1'b1,
      '{iat_pkg::ST_OK,    9'd8, 9'd5, 32'h0}},
    '{iat_pkg::KIND_READ,   8'd0,   32'h0000_0000, 1'b0, '0},
    '{iat_pkg::KIND_UPDATE, 8'd4,   32'hA5A5_A5A5, 1'b0, '0},
    '{iat_pkg::KIND_REMOVE, 8'd4,   32'h0000_0000, 1'b0, '0},
    '{iat_pkg::KIND_REMOVE, 8'd0,   32'h0000_0000, 1'b0, '0},
    '{iat_pkg::KIND_READ,   8'd2,   32'h0000_0000, 1'b0, '0},
    '{KIND_RSVD_B,          8'd1,   32'h5A5A_5A5A, 1'b0, '0},
    '{KIND_RSVD_C,          8'd255, 32'hFFFF_FFFF, 1'b0, '0},
    '{iat_pkg::KIND_UPDATE, 8'd200, 32'h0000_0001, 1'b1,
      '{iat_pkg::ST_RANGE, 9'd8, 9'd3, 32'h0}},
    '{iat_pkg::KIND_REMOVE, 8'd3,   32'h0000_0000, 1'b1,
      '{iat_pkg::ST_RANGE, 9'd8, 9'd3, 32'h0}}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;

  logic signed [31:0] shadow_words [DEPTH];
  int unsigned        shadow_count = 0;
  int unsigned        shadow_cap = 0;
  iat_pkg::res_t      awaited_results [$];
  int                 errors = 0;
  int                 results_seen = 0;
  int                 idle_cycles = 0;
  bit                 send_calm = 1'b0;
  bit                 recv_calm = 1'b0;

  indexed_array_table dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // capacity grows before an accepted append or insert
  function automatic void grow_capacity();
    int unsigned next_cap;
    if (shadow_cap > shadow_count) return;
    next_cap = (shadow_cap == 0) ? 4 : shadow_cap * 2;
    shadow_cap = (next_cap > DEPTH) ? DEPTH : next_cap;
  endfunction

  function automatic iat_pkg::res_t table_op(logic [2:0] kind, logic [7:0] idx,
                                             logic signed [31:0] word);
    iat_pkg::res_t r;
    int            i;
    r = '0;
    r.status = iat_pkg::ST_OK;
    case (kind)
      iat_pkg::KIND_APPEND: begin
        if (shadow_count >= DEPTH) begin
          r.status = iat_pkg::ST_FULL;
        end else begin
          grow_capacity();
          shadow_words[shadow_count] = word;
          shadow_count++;
        end
      end
      iat_pkg::KIND_INSERT: begin
        if (idx >= shadow_count) begin
          r.status = iat_pkg::ST_RANGE;
        end else if (shadow_count >= DEPTH) begin
          r.status = iat_pkg::ST_FULL;
        end else begin
          grow_capacity();
          for (i = shadow_count; i > idx; i--) shadow_words[i] = shadow_words[i - 1];
          shadow_words[idx] = word;
          shadow_count++;
        end
      end
      iat_pkg::KIND_UPDATE: begin
        if (idx >= shadow_count) r.status = iat_pkg::ST_RANGE;
        else shadow_words[idx] = word;
      end
      iat_pkg::KIND_REMOVE: begin
        if (idx >= shadow_count) begin
          r.status = iat_pkg::ST_RANGE;
        end else begin
          for (i = idx; i + 1 < shadow_count; i++) shadow_words[i] = shadow_words[i + 1];
          shadow_count--;
        end
      end
      iat_pkg::KIND_READ: begin
        if (idx >= shadow_count) r.status = iat_pkg::ST_RANGE;
        else r.read_value = shadow_words[idx];
      end
      default: ;
    endcase
    r.size_now = shadow_count[8:0];
    r.capacity_now = shadow_cap[8:0];
    return r;
  endfunction

  // runs of zero gaps alternate with random gaps
  function automatic int draw_gap(inout bit calm);
    if ($urandom_range(0, 39) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 19);
  endfunction

  function automatic logic [2:0] pick_kind(phase_t phase);
    int p;
    p = $urandom_range(0, 99);
    case (phase)
      FILL: begin
        if (p < 45) return iat_pkg::KIND_APPEND;
        if (p < 80) return iat_pkg::KIND_INSERT;
        if (p < 87) return iat_pkg::KIND_UPDATE;
        if (p < 94) return iat_pkg::KIND_READ;
        if (p < 97) return iat_pkg::KIND_REMOVE;
      end
      AT_FULL: begin
        if (p < 35) return iat_pkg::KIND_APPEND;
        if (p < 70) return iat_pkg::KIND_INSERT;
        if (p < 85) return iat_pkg::KIND_READ;
        return iat_pkg::KIND_UPDATE;
      end
      DRAIN: begin
        if (p < 75) return iat_pkg::KIND_REMOVE;
        if (p < 85) return iat_pkg::KIND_READ;
        if (p < 92) return iat_pkg::KIND_UPDATE;
        if (p < 96) return iat_pkg::KIND_APPEND;
        if (p < 98) return iat_pkg::KIND_INSERT;
      end
      default: begin
        if (p < 19) return iat_pkg::KIND_APPEND;
        if (p < 38) return iat_pkg::KIND_INSERT;
        if (p < 57) return iat_pkg::KIND_UPDATE;
        if (p < 76) return iat_pkg::KIND_REMOVE;
        if (p < 95) return iat_pkg::KIND_READ;
      end
    endcase
    return 3'($urandom_range(KIND_RSVD_A, KIND_RSVD_C));
  endfunction

  task automatic push_request(logic [2:0] kind, logic [7:0] idx, logic [31:0] word,
                              bit typed, iat_pkg::res_t want);
    int            gap;
    iat_pkg::res_t predicted;
    gap = draw_gap(send_calm);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, word, idx, kind};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = table_op(kind, idx, word);
    awaited_results.push_back(typed ? want : predicted);
  endtask

  task automatic check_result(iat_pkg::res_t got);
    iat_pkg::res_t want;
    if (awaited_results.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result item %h", got);
    end else begin
      want = awaited_results.pop_front();
      if (got.read_value !== want.read_value || got.size_now !== want.size_now ||
          got.capacity_now !== want.capacity_now || got.status !== want.status) begin
        errors++;
        if (errors <= 10)
          $display({"result %0d: expected value=%0d size=%0d cap=%0d status=%0d,",
                    " got value=%0d size=%0d cap=%0d status=%0d"},
                   results_seen, want.read_value, want.size_now, want.capacity_now,
                   want.status, got.read_value, got.size_now, got.capacity_now,
                   got.status);
      end
    end
  endtask

  // result side
  initial begin
    int gap;
    do @(posedge clk); while (!rst_n);
    forever begin
      gap = (results_seen == HOLD_AT) ? HOLD_CYCLES : draw_gap(recv_calm);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      check_result(iat_pkg::res_t'(out_tdata[51:0]));
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_indexed_array_table: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    phase_t      phase;
    int          left;
    int          n;
    logic [2:0]  kind;
    logic [7:0]  idx;
    logic [31:0] word;
    phase = FILL;
    left = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (n = 0; n < PLAN_LEN; n++)
      push_request(PLAN[n].kind, PLAN[n].index, PLAN[n].value, PLAN[n].typed, PLAN[n].want);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      case (phase)
        FILL: if (shadow_count == DEPTH) begin
          phase = AT_FULL;
          left = 12;
        end
        AT_FULL: if (left == 0) phase = DRAIN;
        DRAIN: if (shadow_count <= 8) begin
          phase = MIXED;
          left = 60;
        end
        default: if (left == 0) phase = FILL;
      endcase
      kind = pick_kind(phase);
      // mostly indexes inside the array, some anywhere
      if (shadow_count > 0 && $urandom_range(0, 9) < 8)
        idx = 8'($urandom_range(0, shadow_count - 1));
      else
        idx = 8'($urandom_range(0, 255));
      case ($urandom_range(0, 15))
        0: word = 32'h8000_0000;
        1: word = 32'h7FFF_FFFF;
        2: word = 32'hFFFF_FFFF;
        3: word = 32'h0000_0000;
        default: word = $urandom;
      endcase
      push_request(kind, idx, word, 1'b0, '0);
      if (left > 0) left--;
    end
    in_tvalid <= 1'b0;

    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);
    if (errors == 0 && awaited_results.size() == 0) begin
      $display("tb_indexed_array_table: done, clean");
    end else begin
      $display("tb_indexed_array_table: done, errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/iat_pkg.sv
rtl/core/iat_ram.sv
rtl/core/iat_ctrl.sv
rtl/core/indexed_array_table.sv
bench/tb_indexed_array_table.sv
